// ----- hdl/hrnt_pkg.sv -----
// shared types and constants for the harris response and corner suppression block
`default_nettype none
package hrnt_pkg;

    // widest column and ring slot indexes over the parameter range
    localparam int COL_MAX_W  = 12;
    localparam int SLOT_MAX_W = 4;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_ALPHA     = 3'd0;
    localparam logic [2:0] CFG_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_WIDTH     = 3'd2;
    localparam logic [2:0] CFG_HEIGHT    = 3'd3;
    localparam logic [2:0] CFG_RADIUS    = 3'd4;

    // effective configuration after clamping
    typedef struct packed {
        logic        [15:0] alpha;
        logic signed [35:0] thr;
        logic        [12:0] w;
        logic        [11:0] h;
        logic        [1:0]  r;
    } t_cfg;

    // classification of one item: where it goes and which pixels it completes
    typedef struct packed {
        logic [COL_MAX_W-1:0]  x;
        logic [SLOT_MAX_W-1:0] yslot;
        logic                  any;
        logic [COL_MAX_W-1:0]  rx0;
        logic [COL_MAX_W-1:0]  rx1;
        logic [11:0]           ry0;
        logic [11:0]           ry1;
        logic [SLOT_MAX_W-1:0] ry0slot;
    } t_meta;

    // one queued job for the back end
    typedef struct packed {
        t_meta              meta;
        logic signed [35:0] resp;
    } t_job;

    // one result item
    typedef struct packed {
        logic [9:0]         col;
        logic [11:0]        row;
        logic signed [35:0] resp;
        logic               corner;
        logic               last;
    } t_res;

endpackage
`default_nettype wire

// ----- hdl/harris_response_nms_threshold.sv -----
// An accepted item passes the front pipeline registers, held under stall, to the job queue.
// Each job is popped and written to the store, then each result steps through center read,
// center latch, window scan, drain and emit, as the single ring read port walks the window.
// Input is accepted every cycle until the 4 entry job queue and front pipeline fill.
// Synchronous active-low reset clears counters, queue, sequencer and configuration
// registers to their defaults; the response ring is not cleared and needs no clearing pass.
`default_nettype none
module harris_response_nms_threshold #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  [2:0]         i_cfg_index,
    input  wire  [35:0]        i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [15:0]        i_sxx,
    input  wire  [15:0]        i_syy,
    input  wire  signed [15:0] i_sxy,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [9:0]         o_pixel_col,
    output logic [11:0]        o_pixel_row,
    output logic signed [35:0] o_response,
    output logic               o_is_corner,
    output logic               o_last_of_run
);
    import hrnt_pkg::*;

    logic [15:0]        r_alpha;
    logic signed [35:0] r_thr;
    logic [10:0]        r_w;
    logic [11:0]        r_h;
    logic [1:0]         r_r;
    t_cfg               cfg;
    logic               push, push_ready, q_valid, q_pop, wr;
    t_job               push_job, q_job;
    t_res               res;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid && o_cfg_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= 16'd3932;
            r_thr   <= '0;
            r_w     <= 11'd640;
            r_h     <= 12'd480;
            r_r     <= 2'd3;
        end else if (wr) begin
            unique case (i_cfg_index)
                CFG_ALPHA:     r_alpha <= i_cfg_data[15:0];
                CFG_THRESHOLD: r_thr   <= i_cfg_data;
                CFG_WIDTH:     r_w     <= i_cfg_data[10:0];
                CFG_HEIGHT:    r_h     <= i_cfg_data[11:0];
                CFG_RADIUS:    r_r     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // clamped working values
    always_comb begin
        cfg.alpha = r_alpha;
        cfg.thr   = r_thr;
        if (r_w == '0) begin
            cfg.w = 13'd1;
        end else if (32'(r_w) > MAX_WIDTH) begin
            cfg.w = 13'(MAX_WIDTH);
        end else begin
            cfg.w = {2'b00, r_w};
        end
        cfg.h = (r_h == '0) ? 12'd1 : r_h;
        cfg.r = (32'(r_r) > MAX_RADIUS) ? 2'(MAX_RADIUS) : r_r;
    end

    hrnt_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sxx        (i_sxx),
        .i_syy        (i_syy),
        .i_sxy        (i_sxy),
        .o_push       (push),
        .o_job        (push_job),
        .i_push_ready (push_ready)
    );

    hrnt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_ready (push_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    hrnt_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_res       (res),
        .i_out_stall (i_out_stall)
    );

    assign o_pixel_col   = res.col;
    assign o_pixel_row   = res.row;
    assign o_response    = res.resp;
    assign o_is_corner   = res.corner;
    assign o_last_of_run = res.last;

endmodule
`default_nettype wire

// ----- hdl/hrnt_front.sv -----
// front end: pixel counters, emission ranges and pipelined response arithmetic
`default_nettype none
module hrnt_front #(
    parameter int MAX_RADIUS = 3
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  hrnt_pkg::t_cfg      i_cfg,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [15:0]         i_sxx,
    input  wire  [15:0]         i_syy,
    input  wire  signed [15:0]  i_sxy,
    output logic                o_push,
    output hrnt_pkg::t_job      o_job,
    input  wire                 i_push_ready
);
    import hrnt_pkg::*;

    localparam int RR = 2 * MAX_RADIUS + 1;

    logic [COL_MAX_W-1:0]  r_col, n_col;
    logic [11:0]           r_row, n_row;
    logic [SLOT_MAX_W-1:0] r_slot, n_slot;

    logic r_s1_v, r_s2_v, r_s3_v;
    logic                en, accept;
    logic [15:0]         r_a, r_d;
    logic signed [15:0]  r_b;
    t_meta               r_m1, r_m2, r_m3, n_meta;
    logic [31:0]         r_ad;
    logic [30:0]         r_bb;
    logic signed [31:0]  bb_full;
    logic [33:0]         r_tt;
    logic signed [33:0]  r_base;
    logic [32:0]         r_plo, r_phi;
    logic [50:0]         sum;
    logic signed [36:0]  resp;

    logic [COL_MAX_W-1:0]  x;
    logic [11:0]           y;
    logic [SLOT_MAX_W-1:0] ys;
    logic [12:0]           x1;
    logic [12:0]           y1;
    logic [11:0]           rdiff;
    logic [SLOT_MAX_W:0]   sdiff;

    assign en         = !r_s3_v || i_push_ready;
    assign o_in_stall = !en;
    assign accept     = i_in_valid && en;
    assign o_push     = r_s3_v && i_push_ready;

    // position of this item, frame restart when counters fall outside
    always_comb begin
        if ({1'b0, r_col} >= i_cfg.w || r_row >= i_cfg.h) begin
            x  = '0;
            y  = '0;
            ys = '0;
        end else begin
            x  = r_col;
            y  = r_row;
            ys = r_slot;
        end
        x1     = {1'b0, x} + 13'd1;
        y1     = {1'b0, y} + 13'd1;
        n_col  = x1[COL_MAX_W-1:0];
        n_row  = y;
        n_slot = ys;
        if (x1 >= i_cfg.w) begin
            n_col  = '0;
            n_row  = y1[11:0];
            n_slot = (32'(ys) == RR - 1) ? '0 : ys + 1'b1;
            if (y1 >= {1'b0, i_cfg.h}) begin
                n_row  = '0;
                n_slot = '0;
            end
        end
    end

    // pixels completed by this item
    always_comb begin
        n_meta       = '0;
        n_meta.x     = x;
        n_meta.yslot = ys;
        n_meta.any   = 1'b1;
        if (y1 == {1'b0, i_cfg.h}) begin
            n_meta.ry0 = (y >= 12'(i_cfg.r)) ? y - 12'(i_cfg.r) : '0;
            n_meta.ry1 = y;
        end else if (y >= 12'(i_cfg.r)) begin
            n_meta.ry0 = y - 12'(i_cfg.r);
            n_meta.ry1 = y - 12'(i_cfg.r);
        end else begin
            n_meta.any = 1'b0;
        end
        if (x1 == i_cfg.w) begin
            n_meta.rx0 = (x >= COL_MAX_W'(i_cfg.r)) ? x - COL_MAX_W'(i_cfg.r) : '0;
            n_meta.rx1 = x;
        end else if (x >= COL_MAX_W'(i_cfg.r)) begin
            n_meta.rx0 = x - COL_MAX_W'(i_cfg.r);
            n_meta.rx1 = x - COL_MAX_W'(i_cfg.r);
        end else begin
            n_meta.any = 1'b0;
        end
        // ring slot of the first completed row
        rdiff = y - n_meta.ry0;
        sdiff = {1'b0, ys} - (SLOT_MAX_W + 1)'(rdiff);
        if (sdiff[SLOT_MAX_W]) begin
            sdiff = sdiff + (SLOT_MAX_W + 1)'(RR);
        end
        n_meta.ry0slot = sdiff[SLOT_MAX_W-1:0];
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_slot <= n_slot;
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    // full width square of the cross term
    assign bb_full = r_b * r_b;

    // products: determinant parts, then alpha times trace squared in two halves
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= i_sxx;
            r_d    <= i_syy;
            r_b    <= i_sxy;
            r_m1   <= n_meta;
            r_ad   <= r_a * r_d;
            r_bb   <= bb_full[30:0];
            r_tt   <= ({17'd0, r_a} + {17'd0, r_d}) * ({17'd0, r_a} + {17'd0, r_d});
            r_m2   <= r_m1;
            r_base <= $signed({2'b00, r_ad}) - $signed({3'b000, r_bb});
            r_plo  <= i_cfg.alpha * r_tt[16:0];
            r_phi  <= i_cfg.alpha * r_tt[33:17];
            r_m3   <= r_m2;
        end
    end

    // rounded trace term and final response
    assign sum  = {1'b0, r_phi, 17'd0} + {18'd0, r_plo} + 51'd32768;
    assign resp = 37'(r_base) - $signed({2'b00, sum[50:16]});

    assign o_job.meta = r_m3;
    assign o_job.resp = resp[35:0];

endmodule
`default_nettype wire

// ----- hdl/hrnt_queue.sv -----
// short job queue between the front and back ends
`default_nettype none
module hrnt_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  hrnt_pkg::t_job  i_data,
    output logic            o_ready,
    input  wire             i_pop,
    output logic            o_valid,
    output hrnt_pkg::t_job  o_data
);
    import hrnt_pkg::*;

    localparam int DEPTH = 4;

    t_job       r_buf [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_ready = r_cnt != 3'(DEPTH);
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_buf[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/hrnt_back.sv -----
// back end: response ring store, neighbourhood scan and result register
`default_nettype none
module hrnt_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  hrnt_pkg::t_cfg  i_cfg,
    input  wire             i_q_valid,
    input  hrnt_pkg::t_job  i_q_data,
    output logic            o_q_pop,
    output logic            o_out_valid,
    output hrnt_pkg::t_res  o_res,
    input  wire             i_out_stall
);
    import hrnt_pkg::*;

    localparam int RR = 2 * MAX_RADIUS + 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = $clog2(RR);
    localparam int AW = SW + CW;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WRITE = 7'b0000010,
        ST_CTR   = 7'b0000100,
        ST_CLAT  = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_job   r_job;

    logic signed [35:0] r_mem [RR << CW];
    logic signed [35:0] r_q, r_center;
    logic [AW-1:0]      rd_addr;

    logic [COL_MAX_W-1:0]  r_px;
    logic [11:0]           r_py;
    logic [SLOT_MAX_W-1:0] r_pslot, r_nslot, nslot0;
    logic [2:0]            r_dx, r_dy;
    logic                  r_rd_v, r_sup, r_out_v;
    t_res                  r_res;
    logic signed [13:0]    ny, nx;
    logic                  inimg, hit, load, last_pix, scan_end;
    logic [2:0]            span;

    assign span     = {i_cfg.r, 1'b0};
    assign ny       = $signed({2'b00, r_py}) - 14'(i_cfg.r) + 14'(r_dy);
    assign nx       = $signed(14'(r_px)) - 14'(i_cfg.r) + 14'(r_dx);
    assign inimg    = ny >= 0 && ny < $signed({2'b00, i_cfg.h})
                   && nx >= 0 && nx < $signed({1'b0, i_cfg.w});
    assign hit      = r_rd_v && (r_q > r_center);
    assign load     = !r_out_v || !i_out_stall;
    assign last_pix = r_px == r_job.meta.rx1 && r_py == r_job.meta.ry1;
    assign scan_end = r_dx == span && r_dy == span;
    assign o_q_pop  = r_state == ST_IDLE && i_q_valid;
    assign nslot0   = (r_pslot >= SLOT_MAX_W'(i_cfg.r)) ? r_pslot - SLOT_MAX_W'(i_cfg.r)
                    : r_pslot + SLOT_MAX_W'(RR) - SLOT_MAX_W'(i_cfg.r);

    // read address: center in the center state, neighbours otherwise
    always_comb begin
        if (r_state == ST_CTR) begin
            rd_addr = {r_pslot[SW-1:0], r_px[CW-1:0]};
        end else begin
            rd_addr = {r_nslot[SW-1:0], nx[CW-1:0]};
        end
    end

    // ring store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_mem[{r_job.meta.yslot[SW-1:0], r_job.meta.x[CW-1:0]}] <= r_job.resp;
        end
        r_q <= r_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_rd_v  <= 1'b0;
        end else begin
            if (r_state == ST_EMIT && load) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_state <= r_job.meta.any ? ST_CTR : ST_IDLE;
                end
                ST_CTR: begin
                    r_state <= ST_CLAT;
                end
                ST_CLAT: begin
                    r_rd_v  <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    r_rd_v <= inimg;
                    if (scan_end) r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    r_rd_v  <= 1'b0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (load) begin
                        r_state <= last_pix ? ST_IDLE : ST_CTR;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // job, pixel walk, neighbour walk and result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_job <= i_q_data;
        if (r_state == ST_WRITE) begin
            r_px    <= r_job.meta.rx0;
            r_py    <= r_job.meta.ry0;
            r_pslot <= r_job.meta.ry0slot;
        end
        if (r_state == ST_CTR) begin
            r_dx    <= '0;
            r_dy    <= '0;
            r_nslot <= nslot0;
        end
        if (r_state == ST_CLAT) begin
            r_center <= r_q;
            r_sup    <= 1'b0;
        end
        if (r_state == ST_SCAN || r_state == ST_DRAIN) begin
            if (hit) r_sup <= 1'b1;
        end
        if (r_state == ST_SCAN) begin
            if (r_dx == span) begin
                r_dx    <= '0;
                r_dy    <= r_dy + 1'b1;
                r_nslot <= (32'(r_nslot) == RR - 1) ? '0 : r_nslot + 1'b1;
            end else begin
                r_dx <= r_dx + 1'b1;
            end
        end
        if (r_state == ST_EMIT && load) begin
            r_res.col    <= r_px[9:0];
            r_res.row    <= r_py;
            r_res.resp   <= r_center;
            r_res.corner <= !r_sup && (r_center > i_cfg.thr);
            r_res.last   <= last_pix;
            if (r_px == r_job.meta.rx1) begin
                r_px    <= r_job.meta.rx0;
                r_py    <= r_py + 1'b1;
                r_pslot <= (32'(r_pslot) == RR - 1) ? '0 : r_pslot + 1'b1;
            end else begin
                r_px <= r_px + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_res       = r_res;

    // a job is taken only when the sequencer is free
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> r_state == ST_IDLE)
        else $error("job popped while busy");

    // neighbour walk stays inside the window
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_dy <= span && r_dx <= span)
        else $error("neighbour walk out of window");

    // an item that completes no pixel goes straight back to idle
    a_empty_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && !r_job.meta.any) |=> r_state == ST_IDLE)
        else $error("empty job not retired");

    // a result is loaded only when the register is free or draining
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_stall) |=> $stable(r_res))
        else $error("pending result overwritten");

endmodule
`default_nettype wire
